// ----- sv/necir_pkg.sv -----
// Types and constants for the NEC infrared pulse decoder.
// Used by the step logic and the top level.
`default_nettype none

package necir_pkg;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_RISE = 2'd1,
		MODE_FALL = 2'd2,
		MODE_READ = 2'd3
	} mode_t;

	localparam logic [13:0] ZERO_LO   = 14'd300;
	localparam logic [13:0] ZERO_HI   = 14'd800;
	localparam logic [13:0] ONE_LO    = 14'd1400;
	localparam logic [13:0] ONE_HI    = 14'd1800;
	localparam logic [13:0] REPEAT_LO = 14'd2200;
	localparam logic [13:0] REPEAT_HI = 14'd2600;
	localparam logic [13:0] LEADER_LO = 14'd4200;
	localparam logic [13:0] LEADER_HI = 14'd4700;

	localparam logic [3:0] TIMEOUT_LIMIT_RESET = 4'd14;

	typedef struct packed {
		logic        frame_active;
		logic        key_ready;
		logic        high_started;
		logic [3:0]  ticks;
		logic [31:0] shift;
		logic [7:0]  repeat_cnt;
	} dec_state_t;

	typedef struct packed {
		mode_t       mode;
		logic [13:0] width_us;
	} pulse_t;

endpackage

`default_nettype wire

// ----- sv/necir_ifs.sv -----
// Valid/ready channel interfaces for pulse events and decoder results.
// Depends on nothing; payload widths are fixed by the decoder.
`default_nettype none

interface necir_pulse_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [13:0] width_us;

	modport source (output valid, output mode, output width_us, input ready);
	modport sink (input valid, input mode, input width_us, output ready);
endinterface

interface necir_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;
	logic [7:0] repeat_count;
	logic       frame_active;
	logic       key_ready;
	logic [3:0] tick_count;

	modport source (output valid, output key_code, output repeat_count,
		output frame_active, output key_ready, output tick_count, input ready);
	modport sink (input valid, input key_code, input repeat_count,
		input frame_active, input key_ready, input tick_count, output ready);
endinterface

`default_nettype wire

// ----- sv/necir_step.sv -----
// Next-state and key-code logic for one pulse event of the NEC decoder.
// Purely combinational; uses types and window constants from necir_pkg.
`default_nettype none

module necir_step
	import necir_pkg::*;
(
	input  dec_state_t cur,
	input  pulse_t     pulse,
	input  logic [3:0] limit,
	output dec_state_t nxt,
	output logic [7:0] key_code
);

	logic       in_zero;
	logic       in_one;
	logic       in_repeat;
	logic       in_leader;
	logic [7:0] cmd;
	logic [7:0] code;

	assign in_zero   = (pulse.width_us > ZERO_LO) && (pulse.width_us < ZERO_HI);
	assign in_one    = (pulse.width_us > ONE_LO) && (pulse.width_us < ONE_HI);
	assign in_repeat = (pulse.width_us > REPEAT_LO) && (pulse.width_us < REPEAT_HI);
	assign in_leader = (pulse.width_us > LEADER_LO) && (pulse.width_us < LEADER_HI);
	assign cmd       = cur.shift[15:8];
	assign code      = (cmd == ~cur.shift[7:0]) ? cmd : 8'd0;

	always_comb begin
		nxt      = cur;
		key_code = 8'd0;
		case (pulse.mode)
			MODE_TICK: begin
				if (cur.frame_active) begin
					nxt.high_started = 1'b0;
					if (cur.ticks == 4'd0) begin
						nxt.key_ready = 1'b1;
					end
					if (cur.ticks < limit) begin
						nxt.ticks = cur.ticks + 4'd1;
					end else begin
						nxt.frame_active = 1'b0;
						nxt.ticks        = 4'd0;
					end
				end
			end
			MODE_RISE: begin
				nxt.high_started = 1'b1;
			end
			MODE_FALL: begin
				if (cur.high_started) begin
					if (cur.frame_active) begin
						if (in_zero) begin
							nxt.shift = {cur.shift[30:0], 1'b0};
						end else if (in_one) begin
							nxt.shift = {cur.shift[30:0], 1'b1};
						end else if (in_repeat) begin
							nxt.repeat_cnt = cur.repeat_cnt + 8'd1;
							nxt.ticks      = 4'd0;
						end
					end else if (in_leader) begin
						nxt.frame_active = 1'b1;
						nxt.repeat_cnt   = 8'd0;
					end
				end
				nxt.high_started = 1'b0;
			end
			MODE_READ: begin
				if (cur.key_ready) begin
					key_code = code;
					if ((code == 8'd0) || !cur.frame_active) begin
						nxt.key_ready  = 1'b0;
						nxt.repeat_cnt = 8'd0;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/nec_ir_pulse_decoder.sv -----
// Top level of the NEC infrared pulse decoder: input register, decoder state,
// result register and timeout configuration. Uses necir_pkg, necir_ifs, necir_step.
//
// Channel   Dir  Payload                                            Beat when
// pulse     in   mode[1:0], width_us[13:0]                          valid & ready
// result    out  key_code, repeat_count, frame_active, key_ready,   valid & ready
//                tick_count
// cfg       in   cfg_wdata[3:0] (timeout limit)                     cfg_we
//
// Each beat is captured in the input register and then decoded into the
// result register; one beat is taken every cycle while the result is not
// stalled. The decoder state updates as a beat leaves the input
// register. A stalled result holds the input register, and pulse.ready then
// follows result.ready. Reset clears all flags, counters and the shift register.
`default_nettype none

module nec_ir_pulse_decoder
	import necir_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	necir_pulse_if.sink     pulse,
	necir_result_if.source  result,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata
);

	logic [3:0] limit_q;
	pulse_t     pulse_s1;
	logic       valid_s1;
	logic       valid_s2;
	logic       advance;
	dec_state_t state_q;
	dec_state_t state_next;
	logic [7:0] code_next;
	logic [7:0] key_code_s2;

	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign pulse.ready = !valid_s1 || !valid_s2 || result.ready;

	necir_step u_step (
		.cur      (state_q),
		.pulse    (pulse_s1),
		.limit    (limit_q),
		.nxt      (state_next),
		.key_code (code_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TIMEOUT_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pulse.ready) begin
			valid_s1 <= pulse.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse.ready && pulse.valid) begin
			pulse_s1.mode     <= mode_t'(pulse.mode);
			pulse_s1.width_us <= pulse.width_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= state_next;
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_code_s2 <= code_next;
		end
	end

	assign result.valid        = valid_s2;
	assign result.key_code     = key_code_s2;
	assign result.repeat_count = state_q.repeat_cnt;
	assign result.frame_active = state_q.frame_active;
	assign result.key_ready    = state_q.key_ready;
	assign result.tick_count   = state_q.ticks;

`ifndef SYNTHESIS
	a_idle_ticks_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.frame_active |-> (state_q.ticks == 4'd0))
		else $error("tick count nonzero without an active frame");

	a_code_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (pulse_s1.mode != MODE_READ)) |=> (key_code_s2 == 8'd0))
		else $error("key code set on a beat that is not a key read");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(pulse_s1)))
		else $error("input register lost a stalled beat");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("decoder state changed without a beat");
`endif

endmodule

`default_nettype wire

// ----- bench/necir_checker.sv -----
// Scoreboard for the NEC infrared pulse decoder: predicts the report of every pulse beat
// and compares each result beat with the oldest prediction, field by field.
// Depends on necir_pkg and the channel interfaces in necir_ifs.
module necir_checker
	import necir_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	necir_pulse_if     pulse,
	necir_result_if    result,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [7:0] key_code;
		logic [7:0] repeats;
		logic       frame_on;
		logic       key_avail;
		logic [3:0] ticks;
	} ir_report_t;

	ir_report_t  owed_reports[$];
	logic        frame_on;
	logic        key_avail;
	logic        high_seen;
	logic [3:0]  tick_cnt;
	logic [3:0]  drop_limit;
	logic [31:0] code_word;
	logic [7:0]  repeats;

	function automatic logic in_window(logic [13:0] w, logic [13:0] lo, logic [13:0] hi);
		return w > lo && w < hi;
	endfunction

	function automatic ir_report_t decode_event(mode_t m, logic [13:0] w);
		ir_report_t rep;
		logic [7:0] cmd;
		rep = '0;
		case (m)
			MODE_TICK: begin
				if (frame_on) begin
					high_seen = 1'b0;
					if (tick_cnt == 4'd0)
						key_avail = 1'b1;
					if (tick_cnt < drop_limit)
						tick_cnt = tick_cnt + 4'd1;
					else begin
						frame_on = 1'b0;
						tick_cnt = 4'd0;
					end
				end
			end
			MODE_RISE: high_seen = 1'b1;
			MODE_FALL: begin
				if (high_seen) begin
					if (frame_on) begin
						if (in_window(w, ZERO_LO, ZERO_HI))
							code_word = {code_word[30:0], 1'b0};
						else if (in_window(w, ONE_LO, ONE_HI))
							code_word = {code_word[30:0], 1'b1};
						else if (in_window(w, REPEAT_LO, REPEAT_HI)) begin
							repeats = repeats + 8'd1;
							tick_cnt = 4'd0;
						end
					end else if (in_window(w, LEADER_LO, LEADER_HI)) begin
						frame_on = 1'b1;
						repeats = 8'd0;
					end
				end
				high_seen = 1'b0;
			end
			default: begin
				if (key_avail) begin
					cmd = code_word[15:8];
					if (cmd == ~code_word[7:0])
						rep.key_code = cmd;
					if (rep.key_code == 8'd0 || !frame_on) begin
						key_avail = 1'b0;
						repeats = 8'd0;
					end
				end
			end
		endcase
		rep.repeats = repeats;
		rep.frame_on = frame_on;
		rep.key_avail = key_avail;
		rep.ticks = tick_cnt;
		return rep;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ir_report_t want;
		if (!arst_n) begin
			frame_on = 1'b0;
			key_avail = 1'b0;
			high_seen = 1'b0;
			tick_cnt = 4'd0;
			drop_limit = TIMEOUT_LIMIT_RESET;
			code_word = '0;
			repeats = 8'd0;
			owed_reports.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (owed_reports.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual %0d %0d %0d %0d %0d",
						$time, result.key_code, result.repeat_count, result.frame_active,
						result.key_ready, result.tick_count);
					fail_count++;
				end else begin
					want = owed_reports.pop_front();
					check_field("key_code", want.key_code, result.key_code);
					check_field("repeat_count", want.repeats, result.repeat_count);
					check_field("frame_active", 8'(want.frame_on), 8'(result.frame_active));
					check_field("key_ready", 8'(want.key_avail), 8'(result.key_ready));
					check_field("tick_count", 8'(want.ticks), 8'(result.tick_count));
				end
			end
			if (pulse.valid && pulse.ready)
				owed_reports.push_back(decode_event(mode_t'(pulse.mode), pulse.width_us));
			if (cfg_we)
				drop_limit = cfg_wdata;
			pending = owed_reports.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// Top of the NEC infrared pulse decoder bench: clock, reset, pulse stimulus, result
// back-pressure, timeout writes and the verdict. Depends on necir_pkg, necir_ifs,
// nec_ir_pulse_decoder and necir_checker.
module tb_top;
	import necir_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        calm;
	logic [3:0]  cur_limit;
	int          fail_count;
	int          pending;
	int          beats_sent;
	logic [13:0] probes [6] = '{ZERO_LO + 14'd1, ZERO_HI, ONE_LO + 14'd1, ONE_HI,
		REPEAT_LO + 14'd1, REPEAT_HI};

	necir_pulse_if  pulse_ch();
	necir_result_if result_ch();

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	nec_ir_pulse_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pulse(pulse_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	necir_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.pulse(pulse_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(negedge clk); while (!result_ch.valid);
			@(posedge clk);
		end
	end

	function automatic logic [13:0] any_width();
		return 14'($urandom_range(0, 10000));
	endfunction

	function automatic logic [13:0] noise_width();
		logic [13:0] base;
		if ($urandom_range(0, 2) != 0)
			return any_width();
		case ($urandom_range(0, 7))
			0: base = ZERO_LO;
			1: base = ZERO_HI;
			2: base = ONE_LO;
			3: base = ONE_HI;
			4: base = REPEAT_LO;
			5: base = REPEAT_HI;
			6: base = LEADER_LO;
			default: base = LEADER_HI;
		endcase
		return base + 14'($urandom_range(0, 2)) - 14'd1;
	endfunction

	task automatic send_pulse(input mode_t m, input logic [13:0] w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			pulse_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pulse_ch.valid <= 1'b1;
		pulse_ch.mode <= m;
		pulse_ch.width_us <= w;
		do @(negedge clk); while (!pulse_ch.ready);
		@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_edge(input logic [13:0] w);
		send_pulse(MODE_RISE, any_width());
		send_pulse(MODE_FALL, w);
	endtask

	task automatic wait_drained();
		pulse_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic set_limit(input logic [3:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_limit = v;
	endtask

	task automatic send_frame(input logic [31:0] word, input int nbits);
		send_edge(LEADER_LO + 14'($urandom_range(1, 499)));
		for (int i = 31; i > 31 - nbits; i--)
			send_edge(word[i] ? ONE_LO + 14'($urandom_range(1, 399))
				: ZERO_LO + 14'($urandom_range(1, 499)));
	endtask

	task automatic run_scene(input bit long_repeat);
		logic [31:0] word;
		logic [7:0]  cmd;
		int          nbits;
		int          actions;
		int          ticks;
		calm = ($urandom_range(0, 3) == 0);
		cmd = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
		word = {16'($urandom), cmd, ~cmd};
		if ($urandom_range(0, 3) == 0)
			word = $urandom;
		nbits = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : 32;
		if ($urandom_range(0, 4) == 0)
			send_pulse(mode_t'($urandom_range(0, 3)), noise_width());
		send_frame(word, nbits);
		actions = long_repeat ? 260 : $urandom_range(2, 10);
		repeat (actions) begin
			case (long_repeat ? 2 : $urandom_range(0, 5))
				0, 1: send_pulse(MODE_TICK, any_width());
				2: send_edge(REPEAT_LO + 14'($urandom_range(1, 399)));
				3: send_pulse(MODE_READ, any_width());
				4: send_pulse(mode_t'($urandom_range(0, 3)), noise_width());
				default: send_edge(noise_width());
			endcase
		end
		if ($urandom_range(0, 5) == 0)
			wait_drained();
		send_pulse(MODE_READ, any_width());
		ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : int'(cur_limit) + 2;
		repeat (ticks)
			send_pulse(MODE_TICK, any_width());
		send_pulse(MODE_READ, any_width());
	endtask

	initial begin
		int scene;
		pulse_ch.valid = 1'b0;
		pulse_ch.mode = MODE_TICK;
		pulse_ch.width_us = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		beats_sent = 0;
		cur_limit = TIMEOUT_LIMIT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle events, window edges, the leader rules and a first key read.
		send_pulse(MODE_TICK, 14'd0);
		send_pulse(MODE_READ, 14'd10000);
		send_pulse(MODE_FALL, LEADER_LO + 14'd100);
		send_edge(LEADER_LO);
		send_edge(LEADER_LO + 14'd1);
		send_edge(LEADER_HI - 14'd1);
		foreach (probes[i])
			send_edge(probes[i]);
		send_pulse(MODE_READ, 14'd0);
		send_pulse(MODE_TICK, 14'd10000);
		send_pulse(MODE_READ, 14'd0);

		scene = 0;
		while (beats_sent < 850) begin
			if (scene % 3 == 0) begin
				case (scene / 3)
					0: set_limit(4'd15);
					1: set_limit(4'd0);
					2: set_limit(4'd1);
					3: set_limit(TIMEOUT_LIMIT_RESET);
					default: set_limit(4'($urandom_range(0, 15)));
				endcase
			end
			run_scene(scene == 4);
			scene++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
